### hdl/lpwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpwm_pkg
// Shared types, constants and helpers for the four-channel LED PWM dither unit.
// ----------------------------------------------------------------------------
package lpwm_pkg;

    localparam int DUTY_W  = 12;
    localparam int LEVEL_W = 8;
    localparam int ACC_W   = 4;
    localparam int NUM_CH  = 4;

    // Work width for a candidate duty before clamping: holds sums, scaled
    // values and the plus/minus one nudge with sign.
    localparam int WORK_W  = 18;

    localparam logic [DUTY_W-1:0] LOW_CAP  = 12'hFF0;
    localparam logic [DUTY_W-1:0] FULL_CAP = 12'hFFF;
    localparam logic [15:0]       Q_ONE    = 16'h1000;

    typedef logic [DUTY_W-1:0]  duty_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [ACC_W-1:0]   acc_t;

    typedef enum logic [2:0] {
        ACT_SET       = 3'd0,
        ACT_ADD       = 3'd1,
        ACT_SCALE     = 3'd2,
        ACT_TICK_LOW  = 3'd3,
        ACT_TICK_HIGH = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        CH_WHITE = 2'd0,
        CH_RED   = 2'd1,
        CH_GREEN = 2'd2,
        CH_BLUE  = 2'd3
    } channel_t;

    // Clamp a signed candidate to 0..4095, then apply the channel cap.
    function automatic duty_t clamp_duty(input logic signed [WORK_W-1:0] value,
                                         input logic low_pair);
        duty_t cap;
        cap = low_pair ? LOW_CAP : FULL_CAP;
        if (value < 0) begin
            clamp_duty = '0;
        end
        else if (value > signed'({{(WORK_W-DUTY_W){1'b0}}, cap})) begin
            clamp_duty = cap;
        end
        else begin
            clamp_duty = value[DUTY_W-1:0];
        end
    endfunction

endpackage

### hdl/four_channel_led_pwm_dither_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_led_pwm_dither_unit
// Four LED duties with set/add/scale commands, sigma-delta dither on the
// white and red 8-bit compares and latched 12-bit compares on green and blue.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_stall  | action, channel, duty_value, delta, factor
//  output  | out_valid / out_stall| white/red/green/blue _compare and _on,
//          |                      | read_duty
//
//  Throughput is one transfer per cycle while out_stall is low; an item passes
//  through the input register and the result register around a single update stage.
//  The 12x16 scale multiply is the longest path of that stage.
//  Reset clears the duties, accumulators, compares and enables to zero at
//  once; no clearing pass is needed, an item can be taken right after reset.
//  A stalled result holds the result register and the held input item;
//  in_stall rises only while an item waits and the result register is full.
//
module four_channel_led_pwm_dither_unit
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic [1:0]         channel,
    input  logic [15:0]        duty_value,
    input  logic signed [15:0] delta,
    input  logic [15:0]        factor,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         white_compare,
    output logic               white_on,
    output logic [7:0]         red_compare,
    output logic               red_on,
    output logic [11:0]        green_compare,
    output logic               green_on,
    output logic [11:0]        blue_compare,
    output logic               blue_on,
    output logic [11:0]        read_duty
);

    localparam int DW = lpwm_pkg::DUTY_W;
    localparam int WW = lpwm_pkg::WORK_W;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic               in_valid_reg;
    logic [2:0]         action_reg;
    logic [1:0]         channel_reg;
    logic [15:0]        value_reg;
    logic signed [15:0] delta_reg;
    logic [15:0]        factor_reg;

    logic               fire;      // held item updates state this cycle
    logic               in_take;   // input transfer this cycle

    // ------------------------------------------------------------------
    // Block state
    // ------------------------------------------------------------------
    lpwm_pkg::duty_t    duty_reg [lpwm_pkg::NUM_CH];
    lpwm_pkg::duty_t    duty_next [lpwm_pkg::NUM_CH];
    lpwm_pkg::acc_t     white_acc_reg, white_acc_next;
    lpwm_pkg::acc_t     red_acc_reg, red_acc_next;
    lpwm_pkg::level_t   white_cmp_reg, white_cmp_next;
    lpwm_pkg::level_t   red_cmp_reg, red_cmp_next;
    lpwm_pkg::duty_t    green_cmp_reg, green_cmp_next;
    lpwm_pkg::duty_t    blue_cmp_reg, blue_cmp_next;
    logic [lpwm_pkg::NUM_CH-1:0] enable_reg, enable_next;

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic               out_valid_reg;
    lpwm_pkg::level_t   res_white_cmp_reg;
    lpwm_pkg::level_t   res_red_cmp_reg;
    lpwm_pkg::duty_t    res_green_cmp_reg;
    lpwm_pkg::duty_t    res_blue_cmp_reg;
    logic [lpwm_pkg::NUM_CH-1:0] res_enable_reg;
    lpwm_pkg::duty_t    res_read_duty_reg;

    // Advance the held item when the result register is empty or draining.
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg  <= action;
            channel_reg <= channel;
            value_reg   <= duty_value;
            delta_reg   <= delta;
            factor_reg  <= factor;
        end
    end

    // ------------------------------------------------------------------
    // Duty update datapath
    // ------------------------------------------------------------------
    lpwm_pkg::duty_t          cur_duty;
    logic                     low_pair;
    logic signed [WW-1:0]     set_value;
    logic signed [WW-1:0]     add_value;
    logic [DW+16-1:0]         product;
    logic [15:0]              scaled;
    logic signed [WW-1:0]     scale_value;
    lpwm_pkg::duty_t          set_duty, add_duty, scale_duty;

    // Sigma-delta step for white and red
    logic [lpwm_pkg::ACC_W:0]   white_sum, red_sum;
    logic [lpwm_pkg::LEVEL_W:0] white_level_w, red_level_w;
    lpwm_pkg::level_t           white_level, red_level;

    assign cur_duty = duty_reg[channel_reg];
    assign low_pair = (channel_reg == lpwm_pkg::CH_WHITE)
                   || (channel_reg == lpwm_pkg::CH_RED);

    assign set_value = signed'({{(WW-16){1'b0}}, value_reg});
    assign add_value = signed'({{(WW-DW){1'b0}}, cur_duty})
                     + signed'({{(WW-16){delta_reg[15]}}, delta_reg});

    assign product = {16'd0, cur_duty} * {{DW{1'b0}}, factor_reg};
    assign scaled  = product[DW+16-1:DW];

    always_comb
    begin
        scale_value = signed'({{(WW-16){1'b0}}, scaled});
        // A scale by a factor other than one that would leave the duty alone still nudges it by one.
        if (scaled == {4'd0, cur_duty})
        begin
            if (factor_reg > lpwm_pkg::Q_ONE)
            begin
                scale_value = scale_value + WW'(1);
            end
            else if (factor_reg < lpwm_pkg::Q_ONE)
            begin
                scale_value = scale_value - WW'(1);
            end
        end
    end

    assign set_duty   = lpwm_pkg::clamp_duty(set_value, low_pair);
    assign add_duty   = lpwm_pkg::clamp_duty(add_value, low_pair);
    assign scale_duty = lpwm_pkg::clamp_duty(scale_value, low_pair);

    assign white_sum     = {1'b0, white_acc_reg} + {1'b0, duty_reg[0][lpwm_pkg::ACC_W-1:0]};
    assign red_sum       = {1'b0, red_acc_reg} + {1'b0, duty_reg[1][lpwm_pkg::ACC_W-1:0]};
    assign white_level_w = {1'b0, duty_reg[0][DW-1:lpwm_pkg::ACC_W]}
                         + {{lpwm_pkg::LEVEL_W{1'b0}}, white_sum[lpwm_pkg::ACC_W]};
    assign red_level_w   = {1'b0, duty_reg[1][DW-1:lpwm_pkg::ACC_W]}
                         + {{lpwm_pkg::LEVEL_W{1'b0}}, red_sum[lpwm_pkg::ACC_W]};
    assign white_level   = white_level_w[lpwm_pkg::LEVEL_W-1:0];
    assign red_level     = red_level_w[lpwm_pkg::LEVEL_W-1:0];

    always_comb
    begin
        lpwm_pkg::duty_t new_duty;
        logic            duty_write;

        for (int k = 0; k < lpwm_pkg::NUM_CH; k++)
        begin
            duty_next[k] = duty_reg[k];
        end
        white_acc_next = white_acc_reg;
        red_acc_next   = red_acc_reg;
        white_cmp_next = white_cmp_reg;
        red_cmp_next   = red_cmp_reg;
        green_cmp_next = green_cmp_reg;
        blue_cmp_next  = blue_cmp_reg;
        enable_next    = enable_reg;
        new_duty       = cur_duty;
        duty_write     = 1'b0;

        unique case (lpwm_pkg::action_t'(action_reg))
            lpwm_pkg::ACT_SET:
            begin
                new_duty   = set_duty;
                duty_write = 1'b1;
            end
            lpwm_pkg::ACT_ADD:
            begin
                new_duty   = add_duty;
                duty_write = 1'b1;
            end
            lpwm_pkg::ACT_SCALE:
            begin
                new_duty   = scale_duty;
                duty_write = 1'b1;
            end
            lpwm_pkg::ACT_TICK_LOW:
            begin
                white_acc_next = white_sum[lpwm_pkg::ACC_W-1:0];
                red_acc_next   = red_sum[lpwm_pkg::ACC_W-1:0];
                // A zero level turns the output off and keeps the old compare.
                if (white_level != '0)
                begin
                    white_cmp_next = white_level;
                end
                if (red_level != '0)
                begin
                    red_cmp_next = red_level;
                end
                enable_next[0] = (white_level != '0);
                enable_next[1] = (red_level != '0);
            end
            lpwm_pkg::ACT_TICK_HIGH:
            begin
                green_cmp_next = duty_reg[2];
                blue_cmp_next  = duty_reg[3];
            end
            default:
            begin
                // Unused codes leave the state alone and still report.
            end
        endcase

        if (duty_write)
        begin
            duty_next[channel_reg] = new_duty;
            // Refresh both enables of the addressed pair.
            if (low_pair)
            begin
                enable_next[0] = (duty_next[0] != '0);
                enable_next[1] = (duty_next[1] != '0);
            end
            else
            begin
                enable_next[2] = (duty_next[2] != '0);
                enable_next[3] = (duty_next[3] != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < lpwm_pkg::NUM_CH; k++)
            begin
                duty_reg[k] <= '0;
            end
            white_acc_reg <= '0;
            red_acc_reg   <= '0;
            white_cmp_reg <= '0;
            red_cmp_reg   <= '0;
            green_cmp_reg <= '0;
            blue_cmp_reg  <= '0;
            enable_reg    <= '0;
        end
        else if (fire)
        begin
            for (int k = 0; k < lpwm_pkg::NUM_CH; k++)
            begin
                duty_reg[k] <= duty_next[k];
            end
            white_acc_reg <= white_acc_next;
            red_acc_reg   <= red_acc_next;
            white_cmp_reg <= white_cmp_next;
            red_cmp_reg   <= red_cmp_next;
            green_cmp_reg <= green_cmp_next;
            blue_cmp_reg  <= blue_cmp_next;
            enable_reg    <= enable_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: capture the post-update view of the state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_white_cmp_reg <= white_cmp_next;
            res_red_cmp_reg   <= red_cmp_next;
            res_green_cmp_reg <= green_cmp_next;
            res_blue_cmp_reg  <= blue_cmp_next;
            res_enable_reg    <= enable_next;
            res_read_duty_reg <= duty_next[channel_reg];
        end
    end

    assign out_valid     = out_valid_reg;
    assign white_compare = res_white_cmp_reg;
    assign white_on      = res_enable_reg[0];
    assign red_compare   = res_red_cmp_reg;
    assign red_on        = res_enable_reg[1];
    assign green_compare = res_green_cmp_reg;
    assign green_on      = res_enable_reg[2];
    assign blue_compare  = res_blue_cmp_reg;
    assign blue_on       = res_enable_reg[3];
    assign read_duty     = res_read_duty_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // White and red never exceed their cap.
    a_low_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (duty_reg[0] <= lpwm_pkg::LOW_CAP) && (duty_reg[1] <= lpwm_pkg::LOW_CAP))
        else $error("white or red duty above cap");

    // Green and blue enables always track their duties.
    a_high_enables: assert property (@(posedge clk) disable iff (!rst_n)
        (enable_reg[2] == (duty_reg[2] != '0)) && (enable_reg[3] == (duty_reg[3] != '0)))
        else $error("green/blue enable out of step with duty");

    // A high tick latches the duties as they stood before the update.
    a_high_latch: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (action_reg == lpwm_pkg::ACT_TICK_HIGH)
        |=> (green_cmp_reg == $past(duty_reg[2])) && (blue_cmp_reg == $past(duty_reg[3])))
        else $error("high tick did not latch green/blue duty");

    // State only moves when an item goes through.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(enable_reg) && $stable(white_acc_reg) && $stable(red_acc_reg)
                  && $stable(white_cmp_reg) && $stable(green_cmp_reg))
        else $error("state changed without an item");

    // Every update fills the result register.
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("update without result");

endmodule
